### rtl/core/chae_pkg.sv
// ============================================================================
// chae_pkg: shared types and constants of the class hierarchy ancestor engine
// Class index widths, walk bounds, operation and status codes, and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package chae_pkg;

    // Class index and table geometry
    localparam int CLS_W       = 6;
    localparam int TABLE_SIZE  = 64;
    localparam int MAX_CLASSES = 64;
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int IDX_W       = $clog2(TABLE_SIZE + 1);
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD_PARENT = 2'd0;
    localparam logic [OP_W-1:0] OP_CONFORM    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMMON_ANC = 2'd2;
    localparam logic [OP_W-1:0] OP_ACYCLIC    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PARENT_SET = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WALK_FAIL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                start;
        logic                wr_parent;
        logic                x_move;
        logic                y_move;
        logic                cnt_dec;
        logic                rewind;
        logic                next_idx;
        logic                set_walk;
        logic                set_res;
        logic                res_flag;
        logic                res_anc;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } chae_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            a_eq_b;
        logic            range_bad;
        logic            def_a;
        logic            x_zero;
        logic            y_zero;
        logic            x_eq_b;
        logic            x_eq_y;
        logic            def_x;
        logic            def_y;
        logic            x_at_max;
        logic            y_at_max;
        logic            x_deeper;
        logic            y_deeper;
        logic            idx_end;
        logic            def_idx;
        logic            seen_hit;
    } chae_stat_t;

endpackage

### rtl/core/chae_datapath.sv
// ============================================================================
// chae_datapath: parent table, walk registers and result registers
// Holds the parent memory (one write port, two registered read ports), the
// defined bits, two walk pointers with link counters, the class sweep index,
// the visited set of the acyclic walk, and the pending and output results.
// ============================================================================
module chae_datapath
    import chae_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [CLS_W-1:0]    s_class_a,
    input  logic [CLS_W-1:0]    s_class_b,
    input  chae_cmd_t           cmd,
    output chae_stat_t          stat,
    output logic                m_answer_flag,
    output logic [CLS_W-1:0]    m_ancestor_class,
    output logic [STATUS_W-1:0] m_status
);

    logic [CLS_W-1:0]      parent_mem [TABLE_SIZE];
    logic [CLS_W-1:0]      rd_x_reg;
    logic [CLS_W-1:0]      rd_y_reg;
    logic [TABLE_SIZE-1:0] defined_reg;
    logic [TABLE_SIZE-1:0] seen_reg;
    logic [OP_W-1:0]       op_reg;
    logic [CLS_W-1:0]      a_reg;
    logic [CLS_W-1:0]      b_reg;
    logic [CLS_W-1:0]      x_reg;
    logic [CLS_W-1:0]      y_reg;
    logic [CNT_W-1:0]      cnt_x_reg;
    logic [CNT_W-1:0]      cnt_y_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  res_flag_reg;
    logic [CLS_W-1:0]      res_anc_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_flag_reg;
    logic [CLS_W-1:0]      out_anc_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    // Parent memory: write on add, read both walk pointers every cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_parent) begin
            parent_mem[a_reg] <= b_reg;
        end
        rd_x_reg <= parent_mem[x_reg];
        rd_y_reg <= parent_mem[y_reg];
    end

    // Defined bits: cleared by reset, set when a parent is recorded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            defined_reg <= '0;
        end else if (cmd.wr_parent) begin
            defined_reg[a_reg] <= 1'b1;
        end
    end

    // Request capture, walk pointers, counters and visited set
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= s_operation;
            a_reg     <= s_class_a;
            b_reg     <= s_class_b;
            x_reg     <= s_class_a;
            y_reg     <= s_class_b;
            cnt_x_reg <= '0;
            cnt_y_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.rewind) begin
                x_reg <= a_reg;
                y_reg <= b_reg;
            end
            if (cmd.set_walk) begin
                x_reg    <= idx_reg[CLS_W-1:0];
                seen_reg <= TABLE_SIZE'(1) << idx_reg[CLS_W-1:0];
            end
            if (cmd.x_move) begin
                x_reg              <= rd_x_reg;
                cnt_x_reg          <= cmd.cnt_dec ? cnt_x_reg - 1'b1 : cnt_x_reg + 1'b1;
                seen_reg[rd_x_reg] <= 1'b1;
            end
            if (cmd.y_move) begin
                y_reg     <= rd_y_reg;
                cnt_y_reg <= cmd.cnt_dec ? cnt_y_reg - 1'b1 : cnt_y_reg + 1'b1;
            end
            if (cmd.next_idx) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Pending result and output register
    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_flag_reg   <= cmd.res_flag;
            res_anc_reg    <= cmd.res_anc ? x_reg : '0;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load) begin
            out_flag_reg   <= res_flag_reg;
            out_anc_reg    <= res_anc_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Status toward the controller
    always_comb begin
        stat.op        = op_reg;
        stat.a_eq_b    = (a_reg == b_reg);
        stat.range_bad = (32'(a_reg) >= MAX_CLASSES) || (32'(b_reg) >= MAX_CLASSES);
        stat.def_a     = defined_reg[a_reg];
        stat.x_zero    = (x_reg == '0);
        stat.y_zero    = (y_reg == '0);
        stat.x_eq_b    = (x_reg == b_reg);
        stat.x_eq_y    = (x_reg == y_reg);
        stat.def_x     = defined_reg[x_reg];
        stat.def_y     = defined_reg[y_reg];
        stat.x_at_max  = (cnt_x_reg >= CNT_W'(MAX_CLASSES));
        stat.y_at_max  = (cnt_y_reg >= CNT_W'(MAX_CLASSES));
        stat.x_deeper  = (cnt_x_reg > cnt_y_reg);
        stat.y_deeper  = (cnt_y_reg > cnt_x_reg);
        stat.idx_end   = (idx_reg == IDX_W'(TABLE_SIZE));
        stat.def_idx   = defined_reg[idx_reg[CLS_W-1:0]];
        stat.seen_hit  = seen_reg[rd_x_reg];
    end

    assign m_answer_flag    = out_flag_reg;
    assign m_ancestor_class = out_anc_reg;
    assign m_status         = out_status_reg;

endmodule

### rtl/core/chae_ctrl.sv
// ============================================================================
// chae_ctrl: request sequencer of the class hierarchy ancestor engine
// Accepts one request, steps the datapath through the walk that the
// operation needs (a check state and an advance state per parent link), and
// hands the result to the output register once it is free.
// ============================================================================
module chae_ctrl
    import chae_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  chae_stat_t stat,
    output chae_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_CONF_CHK = 4'd2;
    localparam logic [3:0] S_CONF_ADV = 4'd3;
    localparam logic [3:0] S_DEP_CHK  = 4'd4;
    localparam logic [3:0] S_DEP_ADV  = 4'd5;
    localparam logic [3:0] S_EQ_CHK   = 4'd6;
    localparam logic [3:0] S_EQ_ADV   = 4'd7;
    localparam logic [3:0] S_MEET_CHK = 4'd8;
    localparam logic [3:0] S_MEET_ADV = 4'd9;
    localparam logic [3:0] S_ACY_CLS  = 4'd10;
    localparam logic [3:0] S_ACY_CHK  = 4'd11;
    localparam logic [3:0] S_ACY_ADV  = 4'd12;
    localparam logic [3:0] S_FINISH   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       x_fail;
    logic       y_fail;

    assign x_fail = !stat.x_zero && (stat.x_at_max || !stat.def_x);
    assign y_fail = !stat.y_zero && (stat.y_at_max || !stat.def_y);

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                case (stat.op)
                    OP_ADD_PARENT: begin
                        cmd.set_res = 1'b1;
                        if (stat.range_bad) begin
                            cmd.res_status = ST_WALK_FAIL;
                        end else if (stat.def_a) begin
                            cmd.res_status = ST_PARENT_SET;
                        end else begin
                            cmd.wr_parent  = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                        state_next = S_FINISH;
                    end
                    OP_CONFORM: begin
                        state_next = S_CONF_CHK;
                    end
                    OP_COMMON_ANC: begin
                        if (stat.a_eq_b) begin
                            cmd.set_res = 1'b1;
                            cmd.res_anc = 1'b1;
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_DEP_CHK;
                        end
                    end
                    default: begin
                        state_next = S_ACY_CLS;
                    end
                endcase
            end

            // Conform: climb from class A looking for class B
            S_CONF_CHK: begin
                if (stat.x_eq_b) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_flag = 1'b1;
                    state_next   = S_FINISH;
                end else if (stat.x_zero) begin
                    cmd.set_res = 1'b1;
                    state_next  = S_FINISH;
                end else if (stat.x_at_max || !stat.def_x) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_WALK_FAIL;
                    state_next     = S_FINISH;
                end else begin
                    state_next = S_CONF_ADV;
                end
            end

            S_CONF_ADV: begin
                cmd.x_move = 1'b1;
                state_next = S_CONF_CHK;
            end

            // Common ancestor: measure both depths together
            S_DEP_CHK: begin
                if (x_fail || y_fail) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_WALK_FAIL;
                    state_next     = S_FINISH;
                end else if (stat.x_zero && stat.y_zero) begin
                    cmd.rewind = 1'b1;
                    state_next = S_EQ_CHK;
                end else begin
                    state_next = S_DEP_ADV;
                end
            end

            S_DEP_ADV: begin
                cmd.x_move = !stat.x_zero;
                cmd.y_move = !stat.y_zero;
                state_next = S_DEP_CHK;
            end

            // Lift the deeper class until both depths match
            S_EQ_CHK: begin
                if (stat.x_deeper || stat.y_deeper) begin
                    state_next = S_EQ_ADV;
                end else begin
                    state_next = S_MEET_CHK;
                end
            end

            S_EQ_ADV: begin
                cmd.cnt_dec = 1'b1;
                cmd.x_move  = stat.x_deeper;
                cmd.y_move  = !stat.x_deeper;
                state_next  = S_EQ_CHK;
            end

            // Climb both together until they meet
            S_MEET_CHK: begin
                if (stat.x_eq_y) begin
                    cmd.set_res = 1'b1;
                    cmd.res_anc = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_MEET_ADV;
                end
            end

            S_MEET_ADV: begin
                cmd.cnt_dec = 1'b1;
                cmd.x_move  = 1'b1;
                cmd.y_move  = 1'b1;
                state_next  = S_MEET_CHK;
            end

            // Acyclic check: sweep classes, walk each defined one to the root
            S_ACY_CLS: begin
                if (stat.idx_end) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_flag = 1'b1;
                    state_next   = S_FINISH;
                end else if (!stat.def_idx) begin
                    cmd.next_idx = 1'b1;
                end else begin
                    cmd.set_walk = 1'b1;
                    state_next   = S_ACY_CHK;
                end
            end

            S_ACY_CHK: begin
                if (stat.x_zero) begin
                    cmd.next_idx = 1'b1;
                    state_next   = S_ACY_CLS;
                end else if (!stat.def_x) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_WALK_FAIL;
                    state_next     = S_FINISH;
                end else begin
                    state_next = S_ACY_ADV;
                end
            end

            S_ACY_ADV: begin
                if (stat.seen_hit) begin
                    cmd.set_res = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.x_move = 1'b1;
                    state_next = S_ACY_CHK;
                end
            end

            // Hold the result until the output register is free
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/core/class_hierarchy_ancestor_engine.sv
// Add parent resolves at dispatch; conform climbs from class A link by link; common
// ancestor answers at dispatch on equal classes, else walks both depths, lifts the
// deeper class to equal depth and climbs both jointly; acyclic check sweeps the table
// and walks each defined class toward the root. A result may wait for the output register.
// One request is served at a time, each link through the registered parent read.
// Reset (aresetn, synchronous) clears all defined bits.
// ============================================================================
// class_hierarchy_ancestor_engine: parent-pointer class hierarchy queries
// Keeps a parent table of class indices rooted at class 0 and serves add
// parent, conform, lowest common ancestor and acyclic check requests.
// ============================================================================
module class_hierarchy_ancestor_engine
    import chae_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [CLS_W-1:0]    s_class_a,
    input  logic [CLS_W-1:0]    s_class_b,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_answer_flag,
    output logic [CLS_W-1:0]    m_ancestor_class,
    output logic [STATUS_W-1:0] m_status
);

    chae_cmd_t  cmd;
    chae_stat_t stat;

    chae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    chae_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_operation      (s_operation),
        .s_class_a        (s_class_a),
        .s_class_b        (s_class_b),
        .cmd              (cmd),
        .stat             (stat),
        .m_answer_flag    (m_answer_flag),
        .m_ancestor_class (m_ancestor_class),
        .m_status         (m_status)
    );

    // One request in flight: accepting a beat drops ready next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_PARENT_SET ||
                     m_status == ST_WALK_FAIL))
        else $error("undefined status code on result beat");

    // An ancestor index and a set answer flag never come together
    a_anc_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ancestor_class != '0 |-> !m_answer_flag)
        else $error("ancestor class and answer flag both set");

    // An ignored add carries zero answer fields
    a_ignored_add: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PARENT_SET |->
            !m_answer_flag && m_ancestor_class == '0)
        else $error("ignored add carries answer fields");

endmodule

### dv/class_hierarchy_ancestor_engine_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// class_hierarchy_ancestor_engine_tb: self-checking bench for the ancestor engine
// Walks a directed table of hierarchy corner cases, then grows a random class
// tree, queries it heavily, and finally lets dangling links and cycles form.
// Every result beat is checked field by field against the directed row's expected answer or the predictor.
// ============================================================================
module class_hierarchy_ancestor_engine_tb;
    import chae_pkg::*;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int LATE_START    = 1200;
    localparam int CALM_FIRST    = 500;
    localparam int CALM_LAST     = 800;
    localparam int TAIL_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 60_000_000;
    localparam int DIRECTED_N    = 25;
    localparam bit TYPED         = 1'b1;
    localparam bit PREDICTED     = 1'b0;

    typedef struct packed {
        logic                flag;
        logic [CLS_W-1:0]    anc;
        logic [STATUS_W-1:0] st;
    } answer_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CLS_W-1:0] a;
        logic [CLS_W-1:0] b;
        logic             typed;
        answer_t          want;
    } request_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [CLS_W-1:0]    s_class_a;
    logic [CLS_W-1:0]    s_class_b;
    logic                m_valid;
    logic                m_ready;
    logic                m_answer_flag;
    logic [CLS_W-1:0]    m_ancestor_class;
    logic [STATUS_W-1:0] m_status;

    // Predictor state
    logic [CLS_W-1:0] parent_of [TABLE_SIZE];
    bit               has_parent [TABLE_SIZE];
    logic [CLS_W-1:0] newest_class;

    answer_t pending_answers [$];
    bit      calm;
    int      mismatches;
    int      results_seen;
    int      ops_sent [4];
    int      walk_fails;
    int      parent_set_hits;
    int      cycles_found;
    int      acyclic_yes;
    int      cycle_count;

    // Corner cases: empty table, root, dangling link, add to the root
    request_row_t directed_rows [DIRECTED_N] = '{
        {OP_CONFORM,    6'd5,  6'd5,  TYPED,     1'b1, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd0,  6'd0,  TYPED,     1'b1, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd0,  6'd7,  TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd63, 6'd0,  TYPED,     1'b0, 6'd0,  ST_WALK_FAIL},
        {OP_COMMON_ANC, 6'd63, 6'd63, TYPED,     1'b0, 6'd63, ST_OK},
        {OP_COMMON_ANC, 6'd0,  6'd0,  TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_COMMON_ANC, 6'd63, 6'd0,  TYPED,     1'b0, 6'd0,  ST_WALK_FAIL},
        {OP_COMMON_ANC, 6'd0,  6'd9,  TYPED,     1'b0, 6'd0,  ST_WALK_FAIL},
        {OP_ACYCLIC,    6'd0,  6'd0,  TYPED,     1'b1, 6'd0,  ST_OK},
        {OP_ADD_PARENT, 6'd1,  6'd0,  TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_ADD_PARENT, 6'd1,  6'd5,  TYPED,     1'b0, 6'd0,  ST_PARENT_SET},
        {OP_ADD_PARENT, 6'd63, 6'd1,  TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_ADD_PARENT, 6'd0,  6'd63, TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd63, 6'd0,  TYPED,     1'b1, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd1,  6'd63, TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_COMMON_ANC, 6'd63, 6'd1,  TYPED,     1'b0, 6'd1,  ST_OK},
        {OP_ADD_PARENT, 6'd2,  6'd62, TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd2,  6'd0,  TYPED,     1'b0, 6'd0,  ST_WALK_FAIL},
        {OP_CONFORM,    6'd2,  6'd62, TYPED,     1'b1, 6'd0,  ST_OK},
        {OP_ACYCLIC,    6'd63, 6'd63, TYPED,     1'b0, 6'd0,  ST_WALK_FAIL},
        {OP_COMMON_ANC, 6'd2,  6'd63, TYPED,     1'b0, 6'd0,  ST_WALK_FAIL},
        {OP_ADD_PARENT, 6'd62, 6'd0,  TYPED,     1'b0, 6'd0,  ST_OK},
        {OP_ACYCLIC,    6'd21, 6'd42, TYPED,     1'b1, 6'd0,  ST_OK},
        {OP_COMMON_ANC, 6'd2,  6'd63, PREDICTED, 1'b0, 6'd0,  ST_OK},
        {OP_CONFORM,    6'd0,  6'd63, TYPED,     1'b0, 6'd0,  ST_OK}
    };

    class_hierarchy_ancestor_engine u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_class_a        (s_class_a),
        .s_class_b        (s_class_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_answer_flag    (m_answer_flag),
        .m_ancestor_class (m_ancestor_class),
        .m_status         (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Links from class c to the root; fails on a dangling link or the bound
    function automatic bit depth_to_root(input logic [CLS_W-1:0] c, output int unsigned d);
        int unsigned n;
        n = 0;
        d = 0;
        while (c != '0) begin
            if (n >= MAX_CLASSES || !has_parent[c]) return 1'b0;
            c = parent_of[c];
            n++;
        end
        d = n;
        return 1'b1;
    endfunction

    // Climb up to n links, halting at the root or a class without a parent
    function automatic logic [CLS_W-1:0] lift(input logic [CLS_W-1:0] c, input int unsigned n);
        while (n > 0 && c != '0 && has_parent[c]) begin
            c = parent_of[c];
            n--;
        end
        return c;
    endfunction

    // Expected answer of one request; an add updates the parent table
    function automatic answer_t resolve_request(input logic [OP_W-1:0] op,
                                                input logic [CLS_W-1:0] a,
                                                input logic [CLS_W-1:0] b);
        answer_t                r;
        logic [CLS_W-1:0]       x;
        logic [CLS_W-1:0]       y;
        logic [CLS_W-1:0]       nxt;
        logic [TABLE_SIZE-1:0]  seen;
        int unsigned            n;
        int unsigned            da;
        int unsigned            db;
        bit                     done;
        bit                     stop;
        r = '0;
        case (op)
            OP_ADD_PARENT: begin
                if (int'(a) >= MAX_CLASSES || int'(b) >= MAX_CLASSES) begin
                    r.st = ST_WALK_FAIL;
                end else if (has_parent[a]) begin
                    r.st = ST_PARENT_SET;
                end else begin
                    parent_of[a]  = b;
                    has_parent[a] = 1'b1;
                    newest_class  = a;
                end
            end
            OP_CONFORM: begin
                x    = a;
                n    = 0;
                done = 1'b0;
                while (!done) begin
                    if (x == b) begin
                        r.flag = 1'b1;
                        done   = 1'b1;
                    end else if (x == '0) begin
                        done = 1'b1;
                    end else if (n >= MAX_CLASSES || !has_parent[x]) begin
                        r.st = ST_WALK_FAIL;
                        done = 1'b1;
                    end else begin
                        x = parent_of[x];
                        n++;
                    end
                end
            end
            OP_COMMON_ANC: begin
                if (a == b) begin
                    r.anc = a;
                end else if (!depth_to_root(a, da) || !depth_to_root(b, db)) begin
                    r.st = ST_WALK_FAIL;
                end else begin
                    x = a;
                    y = b;
                    if (da > db) x = lift(x, da - db);
                    else         y = lift(y, db - da);
                    n = 0;
                    while (x != y && n < TABLE_SIZE) begin
                        x = lift(x, 1);
                        y = lift(y, 1);
                        n++;
                    end
                    r.anc = (x == y) ? x : '0;
                end
            end
            default: begin
                // Walk each defined class toward the root in index order
                r.flag = 1'b1;
                stop   = 1'b0;
                for (int i = 0; i < TABLE_SIZE && !stop; i++) begin
                    if (!has_parent[i]) continue;
                    x       = CLS_W'(i);
                    seen    = '0;
                    seen[i] = 1'b1;
                    while (x != '0) begin
                        if (!has_parent[x]) begin
                            r.flag = 1'b0;
                            r.st   = ST_WALK_FAIL;
                            stop   = 1'b1;
                            break;
                        end
                        nxt = parent_of[x];
                        if (seen[nxt]) begin
                            r.flag = 1'b0;
                            stop   = 1'b1;
                            break;
                        end
                        seen[nxt] = 1'b1;
                        x         = nxt;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] pick_defined();
        logic [CLS_W-1:0] c;
        c = '0;
        for (int t = 0; t < 32; t++) begin
            c = CLS_W'($urandom_range(TABLE_SIZE - 1, 1));
            if (has_parent[c]) return c;
        end
        return c;
    endfunction

    function automatic logic [CLS_W-1:0] pick_undefined(input int lo, input int hi);
        logic [CLS_W-1:0] c;
        c = '0;
        for (int t = 0; t < 64; t++) begin
            c = CLS_W'($urandom_range(hi, lo));
            if (!has_parent[c]) return c;
        end
        return c;
    endfunction

    // Early: grow a tree mostly under classes 1..55; late: hang 56..63, cycles allowed
    function automatic void build_request(input bit late, output logic [OP_W-1:0] op,
                                          output logic [CLS_W-1:0] a,
                                          output logic [CLS_W-1:0] b);
        int               r;
        int               s;
        answer_t          probe;
        logic [CLS_W-1:0] c;
        r = $urandom_range(99);
        s = $urandom_range(9);
        a = CLS_W'($urandom_range(TABLE_SIZE - 1));
        b = CLS_W'($urandom_range(TABLE_SIZE - 1));
        if (r < (late ? 12 : 6)) begin
            op = OP_ADD_PARENT;
            if (!late) begin
                a = pick_undefined(1, 55);
                if (s == 0) a = CLS_W'($urandom_range(TABLE_SIZE - 1));
                if ($urandom_range(99) < 80) begin
                    if ($urandom_range(99) < 40) b = newest_class;
                    else if (s == 1)             b = '0;
                    else                         b = pick_defined();
                end else begin
                    // leave a dangling link until its target gets a parent
                    b = CLS_W'($urandom_range(55));
                end
                // keep the tree acyclic: never hang a class under its own descendant
                probe = resolve_request(OP_CONFORM, b, a);
                if (probe.flag) b = '0;
            end else begin
                a = pick_undefined(56, 63);
                if ($urandom_range(1)) begin
                    // close a loop through a dangling link when one leads to a
                    for (int t = 0; t < 64; t++) begin
                        c     = CLS_W'($urandom_range(TABLE_SIZE - 1));
                        probe = resolve_request(OP_CONFORM, c, a);
                        if (c != a && probe.flag) begin
                            b = c;
                            break;
                        end
                    end
                end
            end
        end else if (r < (late ? 50 : 46)) begin
            op = OP_CONFORM;
            if (s < 5) begin
                a = pick_defined();
                b = lift(a, $urandom_range(8));
            end else if (s == 5) begin
                b = a;
            end
        end else if (r < (late ? 88 : 86)) begin
            op = OP_COMMON_ANC;
            if (s < 7) begin
                a = pick_defined();
                b = pick_defined();
            end else if (s == 7) begin
                a = pick_defined();
                b = '0;
            end
        end else begin
            op = OP_ACYCLIC;
        end
    endfunction

    // Present one request beat, hold it until taken, then record its answer
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CLS_W-1:0] a,
                                input logic [CLS_W-1:0] b, input bit typed,
                                input answer_t want);
        answer_t got;
        while (!calm && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_class_a   <= a;
        s_class_b   <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = resolve_request(op, a, b);
        pending_answers.push_back(typed ? want : got);
        ops_sent[op]++;
        if (got.st == ST_WALK_FAIL)                       walk_fails++;
        if (got.st == ST_PARENT_SET)                      parent_set_hits++;
        if (op == OP_ACYCLIC && got.st == ST_OK)
            if (got.flag) acyclic_yes++;
            else          cycles_found++;
    endtask

    // Result side: random stalls, check each beat against the oldest answer
    initial begin
        answer_t want;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    results_seen++;
                    if (pending_answers.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result beat: flag %0d anc %0d status %0d",
                                     m_answer_flag, m_ancestor_class, m_status);
                    end else begin
                        want = pending_answers.pop_front();
                        if (m_answer_flag !== want.flag || m_ancestor_class !== want.anc ||
                            m_status !== want.st) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("result %0d: expected flag %0d anc %0d status %0d, got flag %0d anc %0d status %0d",
                                         results_seen, want.flag, want.anc, want.st,
                                         m_answer_flag, m_ancestor_class, m_status);
                        end
                    end
                end
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d answers outstanding",
                         cycle_count, pending_answers.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [OP_W-1:0]  op;
        logic [CLS_W-1:0] a;
        logic [CLS_W-1:0] b;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_ADD_PARENT;
        s_class_a    = '0;
        s_class_b    = '0;
        m_ready      = 1'b0;
        calm         = 1'b0;
        newest_class = '0;
        mismatches   = 0;
        results_seen = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].typed, directed_rows[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            if (i == LATE_START) begin
                // hold off until the engine has answered everything
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_answers.size() != 0);
            end
            build_request(i >= LATE_START, op, a, b);
            send_request(op, a, b, PREDICTED, '0);
        end
        calm = 1'b0;

        // Drain and watch for stray beats
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_answers.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatches += pending_answers.size();

        $display("Checked %0d results over %0d add, %0d conform, %0d common ancestor, %0d acyclic requests.",
                 results_seen, ops_sent[OP_ADD_PARENT], ops_sent[OP_CONFORM],
                 ops_sent[OP_COMMON_ANC], ops_sent[OP_ACYCLIC]);
        $display("Walk failures %0d, repeated adds %0d, cycles found %0d, clean hierarchies %0d, mismatches %0d.",
                 walk_fails, parent_set_hits, cycles_found, acyclic_yes, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
